// ===== rtl/core/video_test_pattern_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the test pattern generator
// Shared property wrappers: clocked on the given clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VIDEO_TEST_PATTERN_GENERATOR_DEFINES_SVH
`define VIDEO_TEST_PATTERN_GENERATOR_DEFINES_SVH

// Same-cycle implication
`define VTPG_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vtpg: same-cycle check failed");

// Next-cycle implication
`define VTPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vtpg: next-cycle check failed");

`endif

// ===== rtl/core/vtpg_pkg.sv =====
// ----------------------------------------------------------------------------
// vtpg_pkg
// Widths, window geometry, band codes and mask constants of the pattern.
// ----------------------------------------------------------------------------
`default_nettype none

package vtpg_pkg;

  // field widths
  localparam int XW   = 10;
  localparam int YW   = 9;
  localparam int CW   = 8;
  localparam int CFGW = 10;
  localparam int COLW = 12;   // signed column relative to window
  localparam int ROWW = 11;   // signed row relative to window

  // window geometry
  localparam int WIN_W       = 640;
  localparam int HALF_W      = WIN_W / 2;
  localparam int LEFT_PAD    = 64;
  localparam int TOP_PAD     = 32;
  localparam int RAINBOW_TOP = 24;
  localparam int RG_TOP      = 64;
  localparam int BGR_TOP     = 104;
  localparam int BAND_LINES  = 32;

  // c*255/640 == c*51/128, c*255/320 == c*51/64
  localparam int RAMP_MUL     = 51;
  localparam int DELTA_SHIFT  = 7;
  localparam int RAMP_SHIFT   = 6;
  // c*512/640 == (4*c)/5, done as multiply by 2^14/5 rounded up
  localparam int PHASE_RECIP  = 3277;
  localparam int PHASE_SHIFT  = 14;

  localparam logic [CW-1:0] MASK_3B_BITS = 8'hE0;
  localparam logic [CW-1:0] MASK_4B_BITS = 8'hF0;

  typedef enum logic [1:0] {
    BAND_NONE    = 2'd0,
    BAND_RAINBOW = 2'd1,
    BAND_RG      = 2'd2,
    BAND_BGR     = 2'd3
  } band_t;

  typedef enum logic [1:0] {
    MASK_3B   = 2'd0,
    MASK_4B   = 2'd1,
    MASK_FULL = 2'd2
  } mask_t;

  typedef enum logic {
    REG_OFFSET_H = 1'b0,
    REG_OFFSET_V = 1'b1
  } reg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/core/vtpg_if.sv =====
// ----------------------------------------------------------------------------
// vtpg channel interfaces
// Valid/ready channels for pixel coordinates and pixel colors.
// ----------------------------------------------------------------------------
`default_nettype none

interface vtpg_coord_if;
  import vtpg_pkg::*;
  logic          valid;
  logic          ready;
  logic [XW-1:0] pixel_x;
  logic [YW-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface vtpg_color_if;
  import vtpg_pkg::*;
  logic          valid;
  logic          ready;
  logic [CW-1:0] red;
  logic [CW-1:0] green;
  logic [CW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/video_test_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// video_test_pattern_generator
// Color bar generator: one pixel coordinate in, one 8-bit RGB color out.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake      Payload
//  coord     in    valid/ready    pixel_x[9:0], pixel_y[8:0]
//  color     out   valid/ready    red[7:0], green[7:0], blue[7:0]
//  wr_*      in    wr_en only     wr_index[0], wr_data[9:0]
//
//  One item per cycle sustained while color is ready.
//  Stage 1 offsets the coordinate, stage 2 decodes band and runs the constant
//  multiplies, stage 3 selects and masks the color into the output register.
//  Each stage loads when empty or when the stage after it moves, so a stall
//  on color holds all items in place. Reset clears valid bits and offsets.
// ----------------------------------------------------------------------------
`default_nettype none
`include "video_test_pattern_generator_defines.svh"

module video_test_pattern_generator (
  input  wire                      clk,
  input  wire                      rst,
  vtpg_coord_if.sink               coord,
  vtpg_color_if.source             color,
  input  wire                      wr_en,
  input  wire                      wr_index,
  input  wire [vtpg_pkg::CFGW-1:0] wr_data
);
  import vtpg_pkg::*;

  // configuration
  logic [XW-1:0] offset_h;
  logic [YW-1:0] offset_v;

  // stage 1
  logic                   v1;
  logic signed [COLW-1:0] col1;
  logic signed [ROWW-1:0] row1;

  // stage 2
  logic          v2;
  band_t         band2;
  mask_t         mask2;
  logic          half2;
  logic [CW-1:0] delta2;
  logic [8:0]    phase2;
  logic [CW-1:0] ramp2;

  // stage 3 (output register)
  logic          v3;
  logic [CW-1:0] red_out;
  logic [CW-1:0] green_out;
  logic [CW-1:0] blue_out;

  logic ready1, ready2, ready3;

  // per-stage load enables
  assign ready3      = !v3 || color.ready;
  assign ready2      = !v2 || ready3;
  assign ready1      = !v1 || ready2;
  assign coord.ready = ready1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_h <= '0;
      offset_v <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_OFFSET_H: offset_h <= wr_data[XW-1:0];
        REG_OFFSET_V: offset_v <= wr_data[YW-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: coordinate relative to window origin
  logic [COLW-1:0] col_calc;
  logic [ROWW-1:0] row_calc;
  assign col_calc = COLW'(coord.pixel_x) + COLW'(LEFT_PAD) - COLW'(offset_h);
  assign row_calc = ROWW'(coord.pixel_y) + ROWW'(TOP_PAD) - ROWW'(offset_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= coord.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && coord.valid) begin
      col1 <= $signed(col_calc);
      row1 <= $signed(row_calc);
    end
  end

  // stage 2: band decode and constant multiplies
  logic            col_ok;
  logic [XW-1:0]   c;
  logic [ROWW-2:0] ru;
  logic [4:0]      line;
  band_t           band_calc;
  mask_t           mask_calc;
  logic            half_calc;
  logic [8:0]      c_ramp;
  logic [15:0]     delta_prod;
  logic [11:0]     c_x4;
  logic [23:0]     phase_prod;
  logic [14:0]     ramp_prod;

  assign col_ok = !col1[COLW-1] && ($unsigned(col1) < COLW'(WIN_W));
  assign c      = col1[XW-1:0];
  assign ru     = row1[ROWW-2:0];

  always_comb begin
    line      = '0;
    band_calc = BAND_NONE;
    if (row1[ROWW-1]) begin
      band_calc = BAND_NONE;
    end else if (ru >= (ROWW-1)'(BGR_TOP) && ru < (ROWW-1)'(BGR_TOP + BAND_LINES)) begin
      band_calc = BAND_BGR;
      line      = 5'(ru - (ROWW-1)'(BGR_TOP));
    end else if (ru >= (ROWW-1)'(RG_TOP) && ru < (ROWW-1)'(RG_TOP + BAND_LINES)) begin
      band_calc = BAND_RG;
      line      = 5'(ru - (ROWW-1)'(RG_TOP));
    end else if (ru >= (ROWW-1)'(RAINBOW_TOP)
                 && ru < (ROWW-1)'(RAINBOW_TOP + BAND_LINES)) begin
      band_calc = BAND_RAINBOW;
      line      = 5'(ru - (ROWW-1)'(RAINBOW_TOP));
    end
    if (!col_ok) begin
      band_calc = BAND_NONE;
    end
  end

  always_comb begin
    priority if (line < 5'd8) begin
      mask_calc = MASK_3B;
    end else if (line < 5'd16) begin
      mask_calc = MASK_4B;
    end else begin
      mask_calc = MASK_FULL;
    end
  end

  assign half_calc  = (c >= XW'(HALF_W));
  assign c_ramp     = half_calc ? 9'(c - XW'(HALF_W)) : 9'(c);
  assign delta_prod = 16'(c) * 16'(RAMP_MUL);
  assign c_x4       = {c, 2'b00};
  assign phase_prod = 24'(c_x4) * 24'(PHASE_RECIP);
  assign ramp_prod  = 15'(c_ramp) * 15'(RAMP_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      band2  <= band_calc;
      mask2  <= mask_calc;
      half2  <= half_calc;
      delta2 <= delta_prod[DELTA_SHIFT +: CW];
      phase2 <= phase_prod[PHASE_SHIFT +: 9];
      ramp2  <= ramp_prod[RAMP_SHIFT +: CW];
    end
  end

  // stage 3: color select and bit-depth mask
  logic [CW-1:0] r_sel, g_sel, b_sel, mask_bits;

  always_comb begin
    r_sel = '0;
    g_sel = '0;
    b_sel = '0;
    unique case (band2)
      BAND_RAINBOW: begin
        r_sel = ~delta2;
        b_sel = delta2;
        g_sel = phase2[8] ? ~phase2[CW-1:0] : phase2[CW-1:0];
      end
      BAND_RG: begin
        if (half2) g_sel = ramp2;
        else       r_sel = ramp2;
      end
      BAND_BGR: begin
        b_sel = ramp2;
        if (half2) begin
          r_sel = ramp2;
          g_sel = ramp2;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (mask2)
      MASK_3B:   mask_bits = MASK_3B_BITS;
      MASK_4B:   mask_bits = MASK_4B_BITS;
      default:   mask_bits = '1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      red_out   <= r_sel & mask_bits;
      green_out <= g_sel & mask_bits;
      blue_out  <= b_sel & mask_bits;
    end
  end

  assign color.valid = v3;
  assign color.red   = red_out;
  assign color.green = green_out;
  assign color.blue  = blue_out;

  // checks
  `VTPG_ASSERT_NEXT(a_black_outside, clk, rst, ready3 && v2 && band2 == BAND_NONE, red_out == '0 && green_out == '0 && blue_out == '0)
  `VTPG_ASSERT_NEXT(a_rainbow_sum, clk, rst, ready3 && v2 && band2 == BAND_RAINBOW && mask2 == MASK_FULL, ({1'b0, red_out} + {1'b0, blue_out}) == 9'd255)
  `VTPG_ASSERT_NEXT(a_grey_equal, clk, rst, ready3 && v2 && band2 == BAND_BGR && half2, red_out == green_out && green_out == blue_out)
  `VTPG_ASSERT_NEXT(a_stage1_hold, clk, rst, v1 && !ready2, v1 && $stable(col1) && $stable(row1))

endmodule

`default_nettype wire
